// ===== rtl/hsfl_pkg.sv =====
`default_nettype none
package hsfl_pkg;

   // opcodes carried in req_tuser
   localparam logic [1:0] OP_TRANS = 2'd0;
   localparam logic [1:0] OP_EQUIL = 2'd1;
   localparam logic [1:0] OP_EMIT  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_W      = 5;
   // transition sum: up to MAX_STATES terms of 32 bits
   localparam int XW         = 38;
   localparam int ACC_W      = 48;
   localparam int DIV_BITS   = 32;
   localparam int FRAC_BITS  = 26;

   localparam logic [30:0]      LN2_Q31 = 31'd1488522236;
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [31:0]      LOG_MIN = 32'h8000_0000;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic wr_trans;
      logic wr_eq;
      logic mac_clear;
      logic mac_issue;
      logic emit_mul;
      logic emit_wr;
      logic sum_clear;
      logic sum_issue;
      logic norm_load;
      logic div_step;
      logic prev_wr;
      logic site_clear;
      logic zero_fin;
      logic log_load;
      logic log_shift;
      logic log_mset;
      logic log_sq;
      logic log_fix;
      logic log_mag;
      logic log_fin;
      logic res_load;
      logic res_site;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic op_trans;
      logic op_equil;
      logic op_emit;
      logic oor;
      logic to_last;
      logic mac_busy;
      logic sum_busy;
      logic scale_nz;
      logic norm_top;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/hsfl_ctrl.sv =====
`default_nettype none
module hsfl_ctrl import hsfl_pkg::*; #(
   parameter int MAX_STATES = 16,
   parameter int IW = $clog2(MAX_STATES)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire status_type  st,
   input  wire logic [IW:0] n_states,
   output cmd_type          cmd,
   output logic [IW:0]      idx
);

   typedef enum logic [18:0] {
      S_IDLE   = 19'h00001,
      S_DECODE = 19'h00002,
      S_MAC    = 19'h00004,
      S_MDRAIN = 19'h00008,
      S_EMUL   = 19'h00010,
      S_EWR    = 19'h00020,
      S_SUM    = 19'h00040,
      S_SDRAIN = 19'h00080,
      S_NRD    = 19'h00100,
      S_NLD    = 19'h00200,
      S_NDIV   = 19'h00400,
      S_NWR    = 19'h00800,
      S_LLOAD  = 19'h01000,
      S_LSHIFT = 19'h02000,
      S_LSQ    = 19'h04000,
      S_LFIX   = 19'h08000,
      S_LMAG   = 19'h10000,
      S_LFIN   = 19'h20000,
      S_RESULT = 19'h40000
   } state_type;

   localparam logic [IW:0] LAST_IDX = (IW+1)'(MAX_STATES - 1);
   localparam logic [IW:0] IDX_ONE  = (IW+1)'(1);

   state_type   state_ff, state_in;
   logic [IW:0] idx_ff, idx_in;
   logic [4:0]  bit_ff, bit_in;
   logic        site_ff, site_in;
   logic        idx_end;

   assign idx     = idx_ff;
   assign idx_end = (idx_ff == n_states - IDX_ONE);

   // sequencing
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      bit_in   = bit_ff;
      site_in  = site_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = 1'b1;
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            idx_in  = '0;
            site_in = 1'b0;
            if (st.op_emit && !st.oor) begin
               cmd.mac_clear = 1'b1;
               state_in      = S_MAC;
            end else begin
               cmd.wr_trans = st.op_trans && !st.oor;
               cmd.wr_eq    = st.op_equil && !st.oor;
               state_in     = S_RESULT;
            end
         end
         S_MAC: begin
            cmd.mac_issue = 1'b1;
            if (idx_end) state_in = S_MDRAIN;
            else idx_in = idx_ff + IDX_ONE;
         end
         S_MDRAIN: begin
            if (!st.mac_busy) state_in = S_EMUL;
         end
         S_EMUL: begin
            cmd.emit_mul = 1'b1;
            state_in     = S_EWR;
         end
         S_EWR: begin
            cmd.emit_wr = 1'b1;
            if (st.to_last) begin
               site_in       = 1'b1;
               cmd.sum_clear = 1'b1;
               idx_in        = '0;
               state_in      = S_SUM;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_SUM: begin
            cmd.sum_issue = 1'b1;
            if (idx_end) begin
               idx_in   = '0;
               state_in = S_SDRAIN;
            end else begin
               idx_in = idx_ff + IDX_ONE;
            end
         end
         S_SDRAIN: begin
            if (!st.sum_busy) state_in = S_NRD;
         end
         // normalize every row; rows not in use get zero
         S_NRD: begin
            if (idx_ff < n_states && st.scale_nz) state_in = S_NLD;
            else state_in = S_NWR;
         end
         S_NLD: begin
            cmd.norm_load = 1'b1;
            bit_in        = '0;
            state_in      = S_NDIV;
         end
         S_NDIV: begin
            cmd.div_step = 1'b1;
            if (bit_ff == 5'(DIV_BITS - 1)) state_in = S_NWR;
            else bit_in = bit_ff + 5'd1;
         end
         S_NWR: begin
            cmd.prev_wr = 1'b1;
            if (idx_ff == LAST_IDX) begin
               cmd.site_clear = 1'b1;
               if (st.scale_nz) begin
                  state_in = S_LLOAD;
               end else begin
                  cmd.zero_fin = 1'b1;
                  state_in     = S_RESULT;
               end
            end else begin
               idx_in   = idx_ff + IDX_ONE;
               state_in = S_NRD;
            end
         end
         S_LLOAD: begin
            cmd.log_load = 1'b1;
            state_in     = S_LSHIFT;
         end
         S_LSHIFT: begin
            if (st.norm_top) begin
               cmd.log_mset = 1'b1;
               bit_in       = '0;
               state_in     = S_LSQ;
            end else begin
               cmd.log_shift = 1'b1;
            end
         end
         S_LSQ: begin
            cmd.log_sq = 1'b1;
            state_in   = S_LFIX;
         end
         S_LFIX: begin
            cmd.log_fix = 1'b1;
            if (bit_ff == 5'(FRAC_BITS - 1)) begin
               state_in = S_LMAG;
            end else begin
               bit_in   = bit_ff + 5'd1;
               state_in = S_LSQ;
            end
         end
         S_LMAG: begin
            cmd.log_mag = 1'b1;
            state_in    = S_LFIN;
         end
         S_LFIN: begin
            cmd.log_fin = 1'b1;
            state_in    = S_RESULT;
         end
         S_RESULT: begin
            if (st.out_free) begin
               cmd.res_load = 1'b1;
               cmd.res_site = site_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         site_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         site_ff  <= site_in;
      end
      idx_ff <= idx_in;
      bit_ff <= bit_in;
   end

endmodule
`default_nettype wire

// ===== rtl/hsfl_dp.sv =====
`default_nettype none
module hsfl_dp import hsfl_pkg::*; #(
   parameter int MAX_STATES = 16,
   parameter int IW = $clog2(MAX_STATES)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_wr_data,
   input  wire logic                  req_tvalid,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   input  wire logic                  req_tlast,
   input  wire cmd_type               cmd,
   input  wire logic [IW:0]           idx,
   output status_type                 st,
   output logic [IW:0]                n_states,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int AW = $clog2(MAX_STATES * MAX_STATES);

   // storage
   logic [31:0] trans_mem [MAX_STATES*MAX_STATES];
   logic [31:0] eq_mem    [MAX_STATES];
   logic [31:0] prev_mem  [MAX_STATES];
   logic [63:0] u_mem     [MAX_STATES];

   // captured request
   logic [1:0]  op_ff;
   logic [3:0]  to_ff, from_ff;
   logic [31:0] prob_ff;
   logic        restart_ff, last_ff;

   logic [CSR_W-1:0]      nstates_ff;
   logic                  chain_ff;
   logic                  use_eq_ff;
   logic [MAX_STATES-1:0] u_vld_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [63:0]           scale_ff;

   logic [31:0] t_rd_ff, eq_rd_ff, prev_rd_ff;
   logic [63:0] prod_ff;
   logic        mac_rv_ff, mac_mv_ff;
   logic [XW-1:0] x_ff;
   logic [63:0] emit_ff;

   logic [63:0] u_rd_ff;
   logic        u_rd_vld_ff;
   logic        sum_rv_ff;

   logic [63:0] rem_ff;
   logic [31:0] quo_ff;
   logic        ge_ff;

   logic [63:0] norm_ff;
   logic [5:0]  p_ff;
   logic [31:0] m_ff;
   logic [63:0] sq_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [63:0] lnp_ff;
   logic [31:0] logs_ff;
   logic        zero_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff, rsp_last_ff;

   logic [IW-1:0] to_idx, from_idx, k_idx;
   logic [AW-1:0] t_rd_addr, t_wr_addr;
   logic [63:0]   u_m;
   logic [64:0]   scale_sum;
   logic [31:0]   x_sat;
   logic [64:0]   rem_sh;
   logic          rem_take;
   logic [32:0]   sq_sh;
   logic [32:0]   mag;
   logic [64:0]   lnp_rnd;
   logic [31:0]   mag_q;
   logic [ACC_W:0] acc_diff;
   logic [31:0]   prev_data;
   logic          site_last;

   // states in use, clamped to 1..MAX_STATES
   always_comb begin
      if (nstates_ff == '0) n_states = (IW+1)'(1);
      else if (32'(nstates_ff) > 32'(MAX_STATES)) n_states = (IW+1)'(MAX_STATES);
      else n_states = (IW+1)'(nstates_ff);
   end

   assign to_idx    = IW'(to_ff);
   assign from_idx  = IW'(from_ff);
   assign k_idx     = idx[IW-1:0];
   assign t_rd_addr = AW'(to_idx) * AW'(MAX_STATES) + AW'(k_idx);
   assign t_wr_addr = AW'(to_idx) * AW'(MAX_STATES) + AW'(from_idx);

   // status
   always_comb begin
      st.op_trans = (op_ff == OP_TRANS);
      st.op_equil = (op_ff == OP_EQUIL);
      st.op_emit  = (op_ff == OP_EMIT);
      st.oor      = (32'(to_ff) >= 32'(n_states)) ||
                    ((op_ff == OP_TRANS) && (32'(from_ff) >= 32'(n_states)));
      st.to_last  = (32'(to_ff) == 32'(n_states) - 32'd1);
      st.mac_busy = mac_rv_ff || mac_mv_ff;
      st.sum_busy = sum_rv_ff;
      st.scale_nz = (scale_ff != '0);
      st.norm_top = norm_ff[63];
      st.out_free = !rsp_valid_ff || rsp_tready;
   end

   // arithmetic
   always_comb begin
      u_m       = u_rd_vld_ff ? u_rd_ff : 64'd0;
      scale_sum = {1'b0, scale_ff} + {1'b0, u_m};
      x_sat     = (x_ff > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x_ff[31:0];
      rem_sh    = {rem_ff, 1'b0};
      rem_take  = rem_sh[64] || (rem_sh[63:0] >= scale_ff);
      sq_sh     = sq_ff[63:31];
      mag       = {7'd64 - {1'b0, p_ff}, {FRAC_BITS{1'b0}}} - {7'd0, frac_ff};
      lnp_rnd   = {1'b0, lnp_ff} + 65'h1_0000_0000;
      mag_q     = lnp_rnd[64:33];
      acc_diff  = {acc_ff[ACC_W-1], acc_ff} - {{(ACC_W-31){1'b0}}, mag_q};
      if (32'(idx) >= 32'(n_states) || scale_ff == '0) prev_data = '0;
      else if (ge_ff) prev_data = 32'hFFFF_FFFF;
      else prev_data = quo_ff;
      site_last = cmd.res_site && last_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.wr_trans) trans_mem[t_wr_addr] <= prob_ff;
      if (cmd.wr_eq) eq_mem[to_idx] <= prob_ff;
      if (cmd.prev_wr) prev_mem[k_idx] <= prev_data;
      if (cmd.emit_wr) u_mem[to_idx] <= emit_ff;
      t_rd_ff    <= trans_mem[t_rd_addr];
      eq_rd_ff   <= eq_mem[k_idx];
      prev_rd_ff <= prev_mem[k_idx];
      u_rd_ff    <= u_mem[k_idx];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture && req_tvalid) begin
         op_ff      <= req_tuser;
         to_ff      <= req_tdata[3:0];
         from_ff    <= req_tdata[7:4];
         prob_ff    <= req_tdata[39:8];
         restart_ff <= req_tdata[40];
         last_ff    <= req_tlast;
      end
      if (cmd.mac_clear) use_eq_ff <= restart_ff || !chain_ff;
      u_rd_vld_ff <= u_vld_ff[k_idx];
      // transition products
      prod_ff <= t_rd_ff * (use_eq_ff ? eq_rd_ff : prev_rd_ff);
      if (cmd.mac_clear) x_ff <= '0;
      else if (mac_mv_ff) x_ff <= x_ff + XW'(prod_ff[63:32]);
      if (cmd.emit_mul) emit_ff <= x_sat * prob_ff;
      // restoring divider, one quotient bit a cycle
      if (cmd.norm_load) begin
         rem_ff <= u_m;
         quo_ff <= '0;
         ge_ff  <= (u_m >= scale_ff);
      end else if (cmd.div_step) begin
         rem_ff <= rem_take ? rem_sh[63:0] - scale_ff : rem_sh[63:0];
         quo_ff <= {quo_ff[30:0], rem_take};
      end
      // log2: leading-one search, then repeated squaring
      if (cmd.log_load) begin
         norm_ff <= scale_ff;
         p_ff    <= 6'd63;
      end else if (cmd.log_shift) begin
         norm_ff <= {norm_ff[62:0], 1'b0};
         p_ff    <= p_ff - 6'd1;
      end
      if (cmd.log_mset) m_ff <= norm_ff[63:32];
      else if (cmd.log_fix) m_ff <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
      if (cmd.log_mset) frac_ff <= '0;
      else if (cmd.log_fix) frac_ff <= {frac_ff[FRAC_BITS-2:0], sq_sh[32]};
      if (cmd.log_sq) sq_ff <= m_ff * m_ff;
      if (cmd.log_mag) lnp_ff <= 64'(mag * LN2_Q31);
      if (cmd.log_fin) begin
         logs_ff <= 32'd0 - mag_q;
         zero_ff <= 1'b0;
      end else if (cmd.zero_fin) begin
         logs_ff <= LOG_MIN;
         zero_ff <= 1'b1;
      end
      // result register
      if (cmd.res_load) begin
         rsp_data_ff <= {6'd0, acc_ff, cmd.res_site && zero_ff,
                         cmd.res_site ? logs_ff : 32'd0, cmd.res_site};
         rsp_user_ff <= !st.op_emit && (op_ff != OP_NONE) ? st.oor :
                        (st.op_emit ? st.oor : 1'b0);
         rsp_last_ff <= site_last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         nstates_ff   <= CSR_W'(2);
         chain_ff     <= 1'b0;
         u_vld_ff     <= '0;
         acc_ff       <= '0;
         scale_ff     <= '0;
         mac_rv_ff    <= 1'b0;
         mac_mv_ff    <= 1'b0;
         sum_rv_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) nstates_ff <= csr_wr_data;
         mac_rv_ff <= cmd.mac_issue;
         mac_mv_ff <= mac_rv_ff;
         sum_rv_ff <= cmd.sum_issue;
         if (cmd.site_clear) u_vld_ff <= '0;
         else if (cmd.emit_wr) u_vld_ff[to_idx] <= 1'b1;
         if (cmd.sum_clear) scale_ff <= '0;
         else if (sum_rv_ff) scale_ff <= scale_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF
                                                       : scale_sum[63:0];
         if (cmd.zero_fin) acc_ff <= ACC_MIN;
         else if (cmd.log_fin) acc_ff <= (acc_diff[ACC_W] != acc_diff[ACC_W-1]) ? ACC_MIN
                                                                      : acc_diff[ACC_W-1:0];
         else if (cmd.res_load && site_last) acc_ff <= '0;
         if (cmd.res_load && cmd.res_site) chain_ff <= !last_ff;
         if (cmd.res_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/hmm_scaled_forward_loglik.sv =====
// Scaled HMM forward pass. Each request gives exactly one response. An
// emission runs one transition product per cycle through a 32x32 multiplier
// over the states in use. The emission for the last state also closes the
// site: a scale sum, then, when the scale sum is nonzero, a restoring divider
// at one quotient bit per cycle for each state in use (unused rows are
// written as zero up to MAX_STATES) and a log unit with a one-bit-per-cycle
// leading-one search and 26 squaring steps. A new request is taken while the
// previous response waits.
`default_nettype none
module hmm_scaled_forward_loglik import hsfl_pkg::*; #(
   parameter int MAX_STATES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_wr_data,  // num_states
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // to_state[3:0], from_state[7:4], prob_value[39:8], restart_chain[40]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,    // opcode
   input  wire logic                  req_tlast,    // last_site
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // site_done[0], log_scale[32:1], scale_zero[33], log_likelihood[81:34]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,    // status
   output logic                       rsp_tlast     // total_valid
);

   localparam int IW = $clog2(MAX_STATES);

   cmd_type     cmd;
   status_type  st;
   logic [IW:0] idx;
   logic [IW:0] n_states;

   assign req_tready = cmd.capture;

   hsfl_ctrl #(.MAX_STATES(MAX_STATES), .IW(IW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .st         (st),
      .n_states   (n_states),
      .cmd        (cmd),
      .idx        (idx)
   );

   hsfl_dp #(.MAX_STATES(MAX_STATES), .IW(IW)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .cmd         (cmd),
      .idx         (idx),
      .st          (st),
      .n_states    (n_states),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== rtl/hsfl_checker.sv =====
`default_nettype none
module hsfl_checker import hsfl_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  rsp_tlast
);

   // a stalled response stays up
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a sequence total only comes with a closed site
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[0])
      else $error("total without site");

   // zero scale reports the log floor
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[32:1] == LOG_MIN && rsp_tdata[0])
      else $error("zero scale with bad log");

   // no site, no log value
   a_nolog: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("log without site");

   // an ignored request never closes a site
   a_oor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[0])
      else $error("out of range closed a site");

endmodule

bind hmm_scaled_forward_loglik hsfl_checker u_hsfl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
